// ----- rtl/bmv_pkg.sv -----
package bmv_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int COUNT_W    = 13;
    localparam int SUM_W      = 28;
    localparam int SQSUM_W    = 44;
    localparam int SQ_HALF_W  = 22;
    localparam int MEAN_W     = 24;
    localparam int VAR_W      = 38;
    localparam int FRAC_W     = 8;

    // Shared multiplier: unsigned operands and registered product.
    localparam int MUL_W      = 28;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int NSQ_W      = 57;
    localparam int LO_PROD_W  = COUNT_W + SQ_HALF_W;
    localparam int NN_W       = 2 * COUNT_W - 1;

    // Shared restoring divider.
    localparam int DIV_W      = NSQ_W + FRAC_W;
    localparam int DIVR_W     = NN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // Batch limits and saturation bounds.
    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] MIN_COUNT  = COUNT_W'(1);
    localparam logic [MEAN_W-1:0]  MEAN_MAX   = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0]  MEAN_MIN   = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic [DIV_W-1:0]   MEAN_POS_LIM = DIV_W'(MEAN_MAX);
    localparam logic [DIV_W-1:0]   MEAN_NEG_LIM = DIV_W'(MEAN_MIN);
    localparam logic [VAR_W-1:0]   VAR_MAX    = {VAR_W{1'b1}};

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SAMPLE_COUNT = 1'b0;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/bmv_if.sv -----
// Sample channel: one signed sample per transaction.
interface bmv_sample_if;
    import bmv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Result channel: mean and variance of one batch per transaction.
interface bmv_result_if;
    import bmv_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]         variance_q8;

    modport source (output valid, output mean_q8, output variance_q8, input ready);
    modport sink   (input valid, input mean_q8, input variance_q8, output ready);
endinterface

// ----- rtl/bmv_cfg.sv -----
module bmv_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bmv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bmv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [bmv_pkg::COUNT_W-1:0]     o_batch_size
);
    import bmv_pkg::*;

    logic [COUNT_W-1:0] r_sample_count;
    logic               w_sel_count;
    logic               w_write;

    // Register decode; the low two address bits are ignored by the decode.
    assign w_sel_count = (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_COUNT);
    assign pready      = 1'b1;
    assign w_write     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= MIN_COUNT;
        end else if (w_write && w_sel_count) begin
            r_sample_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Read back the stored value.
    assign prdata = w_sel_count ? APB_DATA_W'(r_sample_count) : '0;

    // A count of zero behaves as one; values above the maximum are capped.
    always_comb begin
        if (r_sample_count == '0) begin
            o_batch_size = MIN_COUNT;
        end else if (r_sample_count > MAX_COUNT) begin
            o_batch_size = MAX_COUNT;
        end else begin
            o_batch_size = r_sample_count;
        end
    end
endmodule

// ----- rtl/bmv_mul.sv -----
module bmv_mul (
    input  logic                        i_clk,
    input  logic [bmv_pkg::MUL_W-1:0]   i_a,
    input  logic [bmv_pkg::MUL_W-1:0]   i_b,
    output logic [bmv_pkg::PROD_W-1:0]  o_prod
);
    import bmv_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Unsigned multiply with a register on the product.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/bmv_div.sv -----
module bmv_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bmv_pkg::t_div_req  i_req,
    output bmv_pkg::t_div_rsp  o_rsp
);
    import bmv_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);
    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(1);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DIVR_W-1:0]    r_rem;
    logic [DIVR_W-1:0]    r_div;
    logic [DIV_W-1:0]     r_quo;
    logic [DIVR_W:0]      w_shift;
    logic                 w_fit;
    logic [DIVR_W-1:0]    n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_W-1]};
        w_fit   = (w_shift >= {1'b0, r_div});
        if (w_fit) begin
            n_rem = DIVR_W'(w_shift - {1'b0, r_div});
        end else begin
            n_rem = w_shift[DIVR_W-1:0];
        end
    end

    // The quotient bits shift in as the dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DIV_STEPS;
                r_rem <= '0;
                r_quo <= i_req.dividend;
                r_div <= i_req.divisor;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - LAST_STEP;
                r_rem  <= n_rem;
                r_quo  <= {r_quo[DIV_W-2:0], w_fit};
                r_done <= (r_cnt == LAST_STEP);
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ----- rtl/batch_mean_variance.sv -----
// Channel   | Direction | Transaction contents
// ----------+-----------+------------------------------------------------
// sample    | in        | sample: signed 16-bit value
// result    | out       | mean_q8 (signed 24), variance_q8 (unsigned 38)
// config    | APB       | sample_count at byte address 0
//
// A sample that does not close a batch is squared on the shared multiplier
// and then accumulated. The sample that closes a batch also takes four
// further passes through the shared multiplier and two 65-step divisions
// on the shared one-bit-per-cycle divider, plus any wait for the output
// register to be taken.
// Reset is synchronous and active low; it clears the accumulators and the
// output valid flag, sets the batch size to one. A finished result waits
// in the output register while further samples are taken; only the next
// result waits for it to be taken.
module batch_mean_variance (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bmv_sample_if.sink                      i_sample_ch,
    bmv_result_if.source                    o_result_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bmv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bmv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bmv_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_NLO  = 4'd3;
    localparam logic [3:0] S_NHI  = 4'd4;
    localparam logic [3:0] S_NN   = 4'd5;
    localparam logic [3:0] S_DIFF = 4'd6;
    localparam logic [3:0] S_DIVM = 4'd7;
    localparam logic [3:0] S_DIVV = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]                 r_state;
    logic signed [SAMPLE_W-1:0] r_s;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQSUM_W-1:0]         r_sumsq;
    logic [COUNT_W-1:0]         r_seen;
    logic [COUNT_W-1:0]         r_n;
    logic [PROD_W-1:0]          r_sq;
    logic [NSQ_W-1:0]           r_nsq;
    logic [NN_W-1:0]            r_nn;
    logic [NSQ_W-1:0]           r_diff;
    logic [MEAN_W-1:0]          r_mean;
    logic [VAR_W-1:0]           r_var;
    logic                       r_out_valid;
    logic [MEAN_W-1:0]          r_out_mean;
    logic [VAR_W-1:0]           r_out_var;

    logic [COUNT_W-1:0]         w_batch_size;
    logic [COUNT_W-1:0]         w_seen_next;
    logic signed [MAG_W-1:0]    w_ext;
    logic [MAG_W-1:0]           w_mag;
    logic [SUM_W-1:0]           w_abs_sum;
    logic [MUL_W-1:0]           w_mul_a;
    logic [MUL_W-1:0]           w_mul_b;
    logic [PROD_W-1:0]          w_prod;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic [MEAN_W-1:0]          w_mean_sat;
    logic [VAR_W-1:0]           w_var_sat;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    bmv_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_batch_size (w_batch_size)
    );

    bmv_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    bmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Handshake terms.
    assign i_sample_ch.ready = (r_state == S_IDLE);
    assign w_in_acc          = i_sample_ch.valid && i_sample_ch.ready;
    assign w_out_free        = !r_out_valid || o_result_ch.ready;

    // Magnitudes for the unsigned multiplier.
    assign w_ext       = MAG_W'(i_sample_ch.sample);
    assign w_mag       = w_ext[MAG_W-1] ? MAG_W'(-w_ext) : MAG_W'(w_ext);
    assign w_abs_sum   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_seen_next = r_seen + COUNT_W'(1);

    // Operand selection for the shared multiplier, one product per state.
    always_comb begin
        case (r_state)
            S_IDLE: begin
                w_mul_a = MUL_W'(w_mag);
                w_mul_b = MUL_W'(w_mag);
            end
            S_SQ: begin
                w_mul_a = MUL_W'(w_abs_sum);
                w_mul_b = MUL_W'(w_abs_sum);
            end
            S_NLO: begin
                w_mul_a = MUL_W'(r_n);
                w_mul_b = MUL_W'(r_sumsq[SQ_HALF_W-1:0]);
            end
            S_NHI: begin
                w_mul_a = MUL_W'(r_n);
                w_mul_b = MUL_W'(r_sumsq[SQSUM_W-1:SQ_HALF_W]);
            end
            S_NN: begin
                w_mul_a = MUL_W'(r_n);
                w_mul_b = MUL_W'(r_n);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Divider requests: mean first, then variance.
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = '0;
        w_div_req.divisor  = '0;
        if (r_state == S_DIFF) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = DIV_W'({w_abs_sum, {FRAC_W{1'b0}}});
            w_div_req.divisor  = DIVR_W'(r_n);
        end else if (r_state == S_DIVM && w_div_rsp.done) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = {r_diff, {FRAC_W{1'b0}}};
            w_div_req.divisor  = r_nn;
        end
    end

    // Apply the sign to the mean magnitude and saturate both results.
    always_comb begin
        if (r_sum[SUM_W-1]) begin
            if (w_div_rsp.quotient > MEAN_NEG_LIM) begin
                w_mean_sat = MEAN_MIN;
            end else begin
                w_mean_sat = MEAN_W'(-w_div_rsp.quotient[MEAN_W-1:0]);
            end
        end else if (w_div_rsp.quotient > MEAN_POS_LIM) begin
            w_mean_sat = MEAN_MAX;
        end else begin
            w_mean_sat = w_div_rsp.quotient[MEAN_W-1:0];
        end
        if (w_div_rsp.quotient > DIV_W'(VAR_MAX)) begin
            w_var_sat = VAR_MAX;
        end else begin
            w_var_sat = w_div_rsp.quotient[VAR_W-1:0];
        end
    end

    // Sequencer and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_seen  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_s     <= i_sample_ch.sample;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum   <= r_sum + SUM_W'(r_s);
                    r_sumsq <= r_sumsq + SQSUM_W'(w_prod);
                    r_seen  <= w_seen_next;
                    if (w_seen_next >= w_batch_size) begin
                        r_n     <= w_seen_next;
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SQ: begin
                    r_state <= S_NLO;
                end
                S_NLO: begin
                    r_sq    <= w_prod;
                    r_state <= S_NHI;
                end
                S_NHI: begin
                    r_nsq   <= NSQ_W'(w_prod[LO_PROD_W-1:0]);
                    r_state <= S_NN;
                end
                S_NN: begin
                    r_nsq   <= r_nsq + NSQ_W'({w_prod[LO_PROD_W-1:0], {SQ_HALF_W{1'b0}}});
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_nn <= w_prod[NN_W-1:0];
                    if (r_nsq > NSQ_W'(r_sq)) begin
                        r_diff <= r_nsq - NSQ_W'(r_sq);
                    end else begin
                        r_diff <= '0;
                    end
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (w_div_rsp.done) begin
                        r_mean  <= w_mean_sat;
                        r_state <= S_DIVV;
                    end
                end
                S_DIVV: begin
                    if (w_div_rsp.done) begin
                        r_var   <= w_var_sat;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_seen  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register; a result is loaded once the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_mean  <= r_mean;
            r_out_var   <= r_var;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.mean_q8     = r_out_mean;
    assign o_result_ch.variance_q8 = r_out_var;
endmodule

// ----- rtl/bmv_checker.sv -----
module bmv_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bmv_pkg::MEAN_W-1:0]   i_mean_q8,
    input logic [bmv_pkg::VAR_W-1:0]    i_variance_q8
);
    import bmv_pkg::*;

    // A waiting result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_mean_q8) && $stable(i_variance_q8))
        else $error("result changed while stalled");

    // An accepted sample makes the block busy, so ready drops after each accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample accepted in back-to-back cycles");

    // A new result only comes out of the batch-closing sequence.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while idle");

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind batch_mean_variance bmv_checker u_bmv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample_ch.valid),
    .i_in_ready    (i_sample_ch.ready),
    .i_out_valid   (o_result_ch.valid),
    .i_out_ready   (o_result_ch.ready),
    .i_mean_q8     (o_result_ch.mean_q8),
    .i_variance_q8 (o_result_ch.variance_q8)
);
